// ===== rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants of the life grid
// Grid size, request codes, beat structs and the row-cell control struct.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int GRID_SIZE = 16;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int ADDR_W    = 4;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  typedef logic [GRID_SIZE-1:0] row_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] cell_row;
    logic [ADDR_W-1:0] cell_col;
    logic              write_alive;
  } in_beat_t;

  typedef struct packed {
    logic       read_alive;
    logic [1:0] ack_type;
  } out_beat_t;

  typedef struct packed {
    logic             shift;
    logic             wr;
    logic [IDX_W-1:0] wr_col;
    logic             wr_val;
  } cell_ctl_t;

endpackage

// ===== rtl/lgs_row_cell.sv =====
// ----------------------------------------------------------------------------
// lgs_row_cell: one grid row in the row chain
// Holds a row of cells; shifts in its neighbor's row during a generation and
// takes single-cell writes otherwise.
// ----------------------------------------------------------------------------
module lgs_row_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  lgs_pkg::cell_ctl_t ctl,
  input  logic             sel,
  input  lgs_pkg::row_t    shift_in,
  output lgs_pkg::row_t    row_q
);
  import lgs_pkg::*;

  row_t row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (ctl.shift) begin
      row_r <= shift_in;
    end else if (ctl.wr && sel) begin
      row_r[ctl.wr_col] <= ctl.wr_val;
    end
  end

  assign row_q = row_r;

endmodule

// ===== rtl/lgs_row_rule.sv =====
// ----------------------------------------------------------------------------
// lgs_row_rule: B3/S23 rule over one row
// Computes the next generation of a row from the row itself and the rows
// above and below, with wraparound at the column edges.
// ----------------------------------------------------------------------------
module lgs_row_rule (
  input  lgs_pkg::row_t up,
  input  lgs_pkg::row_t mid,
  input  lgs_pkg::row_t dn,
  output lgs_pkg::row_t new_row
);
  import lgs_pkg::*;

  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
    localparam int LF = (c + GRID_SIZE - 1) % GRID_SIZE;
    localparam int RT = (c + 1) % GRID_SIZE;
    logic [3:0] n;

    assign n = 4'(up[LF]) + 4'(up[c]) + 4'(up[RT])
             + 4'(mid[LF]) + 4'(mid[RT])
             + 4'(dn[LF]) + 4'(dn[c]) + 4'(dn[RT]);
    assign new_row[c] = (n == 4'd3) || (mid[c] && (n == 4'd2));
  end

endmodule

// ===== rtl/life_grid_generation_step.sv =====
// ----------------------------------------------------------------------------
// life_grid_generation_step: toroidal B3/S23 life grid
// Square grid of one-bit cells kept as a chain of row registers. Requests
// write a cell, read a cell, or advance the grid one generation.
//
// Usage:
//   in_valid/in_stall/in_data carry request beats; out_valid/out_stall/
//   out_data carry one result beat per request (none for request code 3).
//   The result of a write or read shows the cycle after it is taken.
//   A step rotates the row chain once around, one row through the rule
//   logic per cycle, the result in the cycle after the last row. One
//   request is in flight at a time.
//   in_stall is high while a step runs or while a result is held because
//   out_stall is high; a held result stays unchanged until taken.
//   Reset clears every cell to dead and empties the result register.
// ----------------------------------------------------------------------------
module life_grid_generation_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lgs_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lgs_pkg::out_beat_t out_data
);
  import lgs_pkg::*;

  typedef enum logic {ST_IDLE, ST_STEP} state_t;

  state_t           state_r;
  logic [IDX_W-1:0] cnt_r;
  logic             out_valid_r;
  out_beat_t        out_r;
  row_t             prev_r;
  row_t             first_r;

  row_t             row_q [GRID_SIZE];
  row_t             new_row;
  row_t             dn_row;
  cell_ctl_t        ctl;
  logic             accept;
  logic             on_grid;
  logic             last;
  logic [IDX_W-1:0] row_idx;

  assign in_stall = (state_r == ST_STEP) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign on_grid  = (int'(in_data.cell_row) < GRID_SIZE) &&
                    (int'(in_data.cell_col) < GRID_SIZE);
  assign row_idx  = IDX_W'(in_data.cell_row);
  assign last     = (cnt_r == IDX_W'(GRID_SIZE - 1));

  assign ctl.shift  = (state_r == ST_STEP);
  assign ctl.wr     = accept && on_grid && (in_data.req_type == REQ_WRITE);
  assign ctl.wr_col = IDX_W'(in_data.cell_col);
  assign ctl.wr_val = in_data.write_alive;

  for (genvar i = 0; i < GRID_SIZE; i++) begin : g_row
    row_t shift_in;
    if (i == GRID_SIZE - 1) begin : g_tail
      assign shift_in = new_row;
    end else begin : g_body
      assign shift_in = row_q[i+1];
    end
    lgs_row_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sel      (row_idx == IDX_W'(i)),
      .shift_in (shift_in),
      .row_q    (row_q[i])
    );
  end

  assign dn_row = last ? first_r : row_q[1];

  lgs_row_rule u_rule (
    .up      (prev_r),
    .mid     (row_q[0]),
    .dn      (dn_row),
    .new_row (new_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_data.req_type)
              REQ_WRITE: begin
                out_valid_r      <= 1'b1;
                out_r.read_alive <= 1'b0;
                out_r.ack_type   <= REQ_WRITE;
              end
              REQ_READ: begin
                out_valid_r      <= 1'b1;
                out_r.read_alive <= on_grid && row_q[row_idx][IDX_W'(in_data.cell_col)];
                out_r.ack_type   <= REQ_READ;
              end
              REQ_STEP: begin
                state_r <= ST_STEP;
                cnt_r   <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_STEP: begin
          cnt_r <= cnt_r + 1'b1;
          if (last) begin
            state_r          <= ST_IDLE;
            out_valid_r      <= 1'b1;
            out_r.read_alive <= 1'b0;
            out_r.ack_type   <= REQ_STEP;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // old row above the one at the chain head, and the old top row
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      prev_r  <= row_q[GRID_SIZE-1];
      first_r <= row_q[0];
    end else begin
      prev_r  <= row_q[0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/lgs_checker.sv =====
// ----------------------------------------------------------------------------
// lgs_checker: port-level checks of the life grid
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module lgs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input lgs_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input lgs_pkg::out_beat_t out_data
);
  import lgs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_ack_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.ack_type != REQ_NONE)
    else $error("result beat with unused code");

  a_zero_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ack_type != REQ_READ |-> !out_data.read_alive)
    else $error("read_alive set on non-read result");

  a_cell_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_data.req_type == REQ_READ || in_data.req_type == REQ_WRITE)
    |=> out_valid && out_data.ack_type == $past(in_data.req_type))
    else $error("cell access result not on next cycle");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/life_grid_checker.sv =====
// ----------------------------------------------------------------------------
// life_grid_checker: result predictor and comparator for the life grid
// Keeps its own copy of the toroidal B3/S23 grid, updates it on the write and
// step beats taken by the block, queues the result beat each request should give,
// and compares every result beat taken from the block field by field.
// ----------------------------------------------------------------------------
module life_grid_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  lgs_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  lgs_pkg::out_beat_t out_data,
  output int                 mismatches,
  output int                 owed
);
  import lgs_pkg::*;

  localparam int BORN_AT  = 3;
  localparam int KEEP_MIN = 2;
  localparam int PRINT_CAP = 100;

  bit        cells   [GRID_SIZE][GRID_SIZE];
  bit        scratch [GRID_SIZE][GRID_SIZE];
  out_beat_t owed_results [$];
  out_beat_t want;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP)
      $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic int live_around(input int r, input int c);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (dr != 0 || dc != 0)
          n += cells[(r + dr + GRID_SIZE) % GRID_SIZE][(c + dc + GRID_SIZE) % GRID_SIZE];
    return n;
  endfunction

  // whole generation computed from the old grid, then copied back
  function automatic void step_generation();
    int n;
    for (int r = 0; r < GRID_SIZE; r++)
      for (int c = 0; c < GRID_SIZE; c++) begin
        n = live_around(r, c);
        scratch[r][c] = (n == BORN_AT) || (cells[r][c] && n >= KEEP_MIN && n <= BORN_AT);
      end
    cells = scratch;
  endfunction

  function automatic void predict_result(input in_beat_t b);
    out_beat_t exp_beat;
    bit        on_grid;
    on_grid = (int'(b.cell_row) < GRID_SIZE) && (int'(b.cell_col) < GRID_SIZE);
    exp_beat.read_alive = 1'b0;
    exp_beat.ack_type   = b.req_type;
    case (b.req_type)
      REQ_WRITE: begin
        if (on_grid)
          cells[b.cell_row][b.cell_col] = b.write_alive;
      end
      REQ_READ: begin
        if (on_grid)
          exp_beat.read_alive = cells[b.cell_row][b.cell_col];
      end
      REQ_STEP: begin
        step_generation();
      end
      default: begin
      end
    endcase
    if (b.req_type != REQ_NONE)
      owed_results.push_back(exp_beat);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < GRID_SIZE; r++)
        for (int c = 0; c < GRID_SIZE; c++) begin
          cells[r][c]   = 1'b0;
          scratch[r][c] = 1'b0;
        end
      owed_results.delete();
      owed <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected: read_alive=%b ack_type=%0d",
                                    out_data.read_alive, out_data.ack_type));
        end else begin
          want = owed_results.pop_front();
          if (out_data.ack_type !== want.ack_type)
            report_mismatch($sformatf("ack_type %0d, expected %0d",
                                      out_data.ack_type, want.ack_type));
          if (out_data.read_alive !== want.read_alive)
            report_mismatch($sformatf("read_alive %b, expected %b (ack_type %0d)",
                                      out_data.read_alive, want.read_alive, want.ack_type));
        end
      end
      if (in_valid && !in_stall)
        predict_result(in_data);
      owed <= owed_results.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top of the life grid generation step
// Drives directed and random write, read, step and no-op request beats with random
// gaps and output stalls, long output holds and full drains; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
  import lgs_pkg::*;

  localparam int LONG_HOLD      = 60;
  localparam int WATCHDOG_LIMIT = 600;
  localparam int RANDOM_ITEMS   = 880;
  localparam int QUIET_TAIL     = 100;
  localparam int IN_W           = $bits(in_beat_t);

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  int mismatches;
  int owed;
  bit quiet;
  bit hold_out;
  int hold_left;
  int idle_cycles;

  life_grid_generation_step uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  life_grid_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .owed       (owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_beat_t make_req(input logic [1:0] kind, input int r, input int c,
                                        input int alive);
    in_beat_t b;
    b.req_type    = kind;
    b.cell_row    = ADDR_W'(r);
    b.cell_col    = ADDR_W'(c);
    b.write_alive = 1'(alive);
    return b;
  endfunction

  task automatic send_req(input in_beat_t b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= IN_W'($urandom);
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed != 0) @(negedge clk);
  endtask

  // receiver holds off while beats keep coming, so the block backs up
  task automatic hold_and_flood();
    bit was_quiet;
    was_quiet = quiet;
    quiet     = 1'b1;
    hold_out  = 1'b1;
    for (int i = 0; i < 8; i++)
      send_req(make_req(2'($urandom_range(0, 1)), $urandom, $urandom, $urandom));
    send_req(make_req(REQ_STEP, $urandom, $urandom, $urandom));
    drain();
    quiet = was_quiet;
  endtask

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_out) begin
        hold_out  = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    wait (rst_n);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    int gr [5] = '{0, 1, 2, 2, 2};
    int gc [5] = '{1, 2, 0, 1, 2};
    int issued;
    int next_mark;
    int pick;
    int r0;
    int c0;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    quiet    = 1'b0;
    hold_out = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty grid, wrapped corner block, wrapped blinker, no-op codes
    send_req(make_req(REQ_READ, 0, 0, 1));
    send_req(make_req(REQ_WRITE, 0, 0, 1));
    send_req(make_req(REQ_WRITE, 0, 15, 1));
    send_req(make_req(REQ_WRITE, 15, 0, 1));
    send_req(make_req(REQ_WRITE, 15, 15, 1));
    send_req(make_req(REQ_READ, 15, 15, 0));
    send_req(make_req(REQ_STEP, 15, 15, 1));
    send_req(make_req(REQ_READ, 0, 0, 0));
    send_req(make_req(REQ_READ, 15, 15, 1));
    send_req(make_req(REQ_READ, 8, 8, 0));
    send_req(make_req(REQ_WRITE, 15, 15, 0));
    send_req(make_req(REQ_READ, 15, 15, 0));
    send_req(make_req(REQ_WRITE, 7, 15, 1));
    send_req(make_req(REQ_WRITE, 7, 0, 1));
    send_req(make_req(REQ_WRITE, 7, 1, 1));
    send_req(make_req(REQ_STEP, 0, 0, 0));
    send_req(make_req(REQ_READ, 6, 0, 0));
    send_req(make_req(REQ_READ, 8, 0, 1));
    send_req(make_req(REQ_READ, 7, 15, 0));
    send_req(make_req(REQ_NONE, 15, 15, 1));
    send_req(make_req(REQ_NONE, 0, 0, 0));
    send_req(make_req(REQ_STEP, $urandom, $urandom, $urandom));
    send_req(make_req(REQ_READ, 15, 0, $urandom));
    drain();
    hold_and_flood();

    issued    = 0;
    next_mark = 50;
    while (issued < RANDOM_ITEMS) begin
      if (issued >= next_mark) begin
        next_mark += 50;
        if (issued >= RANDOM_ITEMS - QUIET_TAIL)
          quiet = 1'b1;
        else
          quiet = ($urandom_range(0, 3) == 0);
        if (issued % 150 < 50)
          drain();
        if (issued >= RANDOM_ITEMS / 2 && issued < RANDOM_ITEMS / 2 + 50)
          hold_and_flood();
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        r0 = $urandom_range(0, GRID_SIZE - 1);
        c0 = $urandom_range(0, GRID_SIZE - 1);
        for (int k = 0; k < 5; k++)
          send_req(make_req(REQ_WRITE, (r0 + gr[k]) % GRID_SIZE, (c0 + gc[k]) % GRID_SIZE, 1));
        issued += 5;
      end else if (pick < 45) begin
        send_req(make_req(REQ_WRITE, $urandom, $urandom, $urandom));
        issued++;
      end else if (pick < 80) begin
        send_req(make_req(REQ_READ, $urandom, $urandom, $urandom));
        issued++;
      end else if (pick < 95) begin
        send_req(make_req(REQ_STEP, $urandom, $urandom, $urandom));
        issued++;
      end else begin
        send_req(make_req(REQ_NONE, $urandom, $urandom, $urandom));
      end
    end

    quiet = 1'b1;
    drain();
    repeat (GRID_SIZE + 8) @(negedge clk);
    if (mismatches == 0 && owed == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// ===== life_grid_generation_step.f =====
rtl/lgs_pkg.sv
rtl/lgs_row_cell.sv
rtl/lgs_row_rule.sv
rtl/life_grid_generation_step.sv
rtl/lgs_checker.sv
tb/life_grid_checker.sv
tb/tb.sv
